@@ design/kmhrb_pkg.sv @@
// package: constants, key-code rom and shared types for the hid report builder
package kmhrb_pkg;

    localparam int ROWS           = 14;
    localparam int COLS           = 8;
    localparam int PWM_FULL_SCALE = 1023;
    localparam int NSLOTS         = 6;
    localparam int ROM_ROWS       = 14;
    localparam int COL_W          = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ROW_AW         = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [7:0]  COL_MASK  = 8'((1 << COLS) - 1);
    localparam logic [7:0]  CODE_NONE = 8'h00;
    localparam logic [7:0]  CODE_FN   = 8'hFF;
    localparam logic [7:0]  CODE_Z    = 8'h1D;
    localparam logic [7:0]  CODE_X    = 8'h1B;
    localparam logic [7:0]  CODE_C    = 8'h06;
    localparam logic [7:0]  MOD_FIRST = 8'hE0;
    localparam logic [7:0]  MOD_LAST  = 8'hE7;
    localparam logic [15:0] BL_STEP   = 16'd64;
    localparam logic [15:0] BL_FULL   = 16'(PWM_FULL_SCALE);

    typedef logic [7:0] t_code;
    typedef t_code [NSLOTS-1:0] t_slots;

    typedef struct packed {
        logic        fn;
        logic [15:0] bright;
        logic [7:0]  mods;
        t_slots      slots;
    } t_kstate;

    typedef struct packed {
        logic        kind;
        logic [7:0]  mods;
        t_slots      slots;
        logic [15:0] bright;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    made;
        t_kstate st;
        t_result res;
    } t_evt;

    localparam t_code CODE_ROM [ROM_ROWS][8] = '{
        '{8'h1E, 8'h2B, 8'h14, 8'h39, 8'h04, 8'hE1, 8'h1D, 8'h35},
        '{8'h20, 8'h1A, 8'h08, 8'h16, 8'h07, 8'h1B, 8'h06, 8'h1F},
        '{8'h22, 8'h15, 8'h17, 8'h09, 8'h0A, 8'h19, 8'h05, 8'h21},
        '{8'h24, 8'h1C, 8'h18, 8'h0B, 8'h0D, 8'h11, 8'h10, 8'h23},
        '{8'h26, 8'h0C, 8'h12, 8'h0E, 8'h0F, 8'h36, 8'h37, 8'h25},
        '{8'h2D, 8'h13, 8'h2F, 8'h33, 8'h34, 8'h38, 8'hE5, 8'h27},
        '{8'h2A, 8'h30, 8'h31, 8'h28, 8'h00, 8'hE4, 8'hFF, 8'h2E},
        '{8'h4A, 8'h4C, 8'h4D, 8'h00, 8'h52, 8'h51, 8'h50, 8'h00},
        '{8'h00, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h4F, 8'h00, 8'h4B},
        '{8'h00, 8'hE2, 8'hE0, 8'hE3, 8'h2C, 8'hE6, 8'h00, 8'h00},
        '{8'h3A, 8'h3B, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h29},
        '{8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3D},
        '{8'h41, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40},
        '{8'h44, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h43}
    };

    function automatic t_code rom_code(input logic [3:0] row, input logic [2:0] col);
        t_code code;
        code = CODE_NONE;
        if (row < 4'(ROM_ROWS)) begin
            code = CODE_ROM[row][col];
        end
        return code;
    endfunction

endpackage

@@ design/kmhrb_if.sv @@
// interfaces: scanned row input channel and report output channel
interface kmhrb_row_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_index;
    logic [7:0] column_bits;

    modport source (output valid, output row_index, output column_bits, input ready);
    modport sink   (input valid, input row_index, input column_bits, output ready);
endinterface

interface kmhrb_rep_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  modifier_byte;
    logic [7:0]  slot0;
    logic [7:0]  slot1;
    logic [7:0]  slot2;
    logic [7:0]  slot3;
    logic [7:0]  slot4;
    logic [7:0]  slot5;
    logic [15:0] brightness;
    logic        last;

    modport source (output valid, output kind, output modifier_byte, output slot0,
                    output slot1, output slot2, output slot3, output slot4, output slot5,
                    output brightness, output last, input ready);
    modport sink   (input valid, input kind, input modifier_byte, input slot0,
                    input slot1, input slot2, input slot3, input slot4, input slot5,
                    input brightness, input last, output ready);
endinterface

@@ design/key_matrix_hid_report_builder.sv @@
// top level: keyboard matrix row scanner building hid boot-keyboard reports
//
// input channel i_row carries one scanned row (row_index, column_bits). the
// block compares it with the stored copy of that row and handles each changed
// column from 0 upward, one column a cycle unless the scan stalls. every press
// or release that gets through gives one word on o_rep: a keyboard report
// (kind 0) or, with fn held and z/x/c pressed, a backlight command (kind 1).
// last marks the final word caused by a row; a row causing no word gives
// nothing. a row passes through the accepting state, a read of the stored row
// from the row ram, the column scan through the event unit and a flush of the
// held-back final word. ready is high only between rows. a row index not below
// ROWS is accepted and changes nothing. one word is held back until the next
// one or the end of the row shows whether it is the last; a stalled receiver
// holds the output register and stops the column scan when a column makes a
// word while both registers are full.
// after reset all rows read as released (per-row valid bits), slots, modifiers,
// fn and brightness are zero, and no word is pending.
module key_matrix_hid_report_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kmhrb_row_if.sink   i_row,
    kmhrb_rep_if.source o_rep
);
    import kmhrb_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_SCAN, S_FLUSH} t_state;

    t_state             r_state;
    logic [3:0]         r_row;
    logic [7:0]         r_now;
    logic [7:0]         r_diff;
    logic [COL_W-1:0]   r_col;
    t_kstate            r_st;
    logic               r_pend_v;
    t_result            r_pend;
    logic               r_out_v;
    t_result            r_out;
    logic [ROWS-1:0]    r_row_vld;
    logic               r_rd_vld;

    logic [7:0]         ram_rdata;
    logic [7:0]         prior;
    logic               row_ok;
    logic               accept;
    logic [7:0]         code;
    logic               change;
    logic               made;
    logic               out_free;
    logic               stall;
    t_evt               evt;

    assign row_ok   = {1'b0, i_row.row_index} < 5'(ROWS);
    assign accept   = i_row.valid && i_row.ready;
    assign code     = rom_code(r_row, 3'(r_col));
    assign change   = r_diff[r_col];
    assign made     = change && evt.made;
    assign out_free = !r_out_v || o_rep.ready;
    assign stall    = (r_state == S_SCAN) && made && r_pend_v && !out_free;
    assign prior    = r_rd_vld ? ram_rdata : 8'h00;

    kmhrb_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_row[ROW_AW-1:0]),
        .i_wdata (r_now),
        .i_raddr (i_row.row_index[ROW_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    kmhrb_event u_event (
        .i_st    (r_st),
        .i_code  (code),
        .i_press (r_now[r_col]),
        .o_evt   (evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_st      <= '0;
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_col     <= '0;
        end else begin
            if (r_out_v && o_rep.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && row_ok) begin
                        r_row    <= i_row.row_index;
                        r_now    <= i_row.column_bits & COL_MASK;
                        r_rd_vld <= r_row_vld[i_row.row_index[ROW_AW-1:0]];
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_diff                       <= (r_now ^ prior) & COL_MASK;
                    r_row_vld[r_row[ROW_AW-1:0]] <= 1'b1;
                    r_col                        <= '0;
                    r_state                      <= S_SCAN;
                end
                S_SCAN: begin
                    if (!stall) begin
                        if (change) begin
                            r_st <= evt.st;
                        end
                        if (made) begin
                            if (r_pend_v) begin
                                r_out   <= r_pend;
                                r_out_v <= 1'b1;
                            end
                            r_pend   <= evt.res;
                            r_pend_v <= 1'b1;
                        end
                        if (r_col == COL_W'(COLS - 1)) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_col <= r_col + COL_W'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out    <= {r_pend[$bits(t_result)-1:1], 1'b1};
                        r_out_v  <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_row.ready         = (r_state == S_IDLE);
    assign o_rep.valid         = r_out_v;
    assign o_rep.kind          = r_out.kind;
    assign o_rep.modifier_byte = r_out.mods;
    assign o_rep.slot0         = r_out.slots[0];
    assign o_rep.slot1         = r_out.slots[1];
    assign o_rep.slot2         = r_out.slots[2];
    assign o_rep.slot3         = r_out.slots[3];
    assign o_rep.slot4         = r_out.slots[4];
    assign o_rep.slot5         = r_out.slots[5];
    assign o_rep.brightness    = r_out.bright;
    assign o_rep.last          = r_out.last;

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("word still pending between rows");

    a_bad_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !row_ok) |=> (r_state == S_IDLE) && !r_pend_v)
        else $error("out-of-range row started a scan");

    a_push_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && made && r_pend_v && out_free) |=> (r_out_v && !r_out.last))
        else $error("mid-row word lost or marked last");

    a_report_no_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.kind) |-> (r_out.bright == 16'h0000))
        else $error("keyboard report carries a brightness level");
endmodule

@@ design/kmhrb_ram.sv @@
// generic single-write, single-read ram with registered read data
module kmhrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/kmhrb_event.sv @@
// key event unit: applies one press or release to fn, brightness, modifiers and slots
module kmhrb_event (
    input  kmhrb_pkg::t_kstate i_st,
    input  logic [7:0]         i_code,
    input  logic               i_press,
    output kmhrb_pkg::t_evt    o_evt
);
    import kmhrb_pkg::*;

    t_kstate    st;
    t_result    res;
    logic       made;
    logic       hot;
    logic       is_mod;
    logic       present;
    logic       found;
    logic [7:0] mod_bit;

    always_comb begin
        st      = i_st;
        res     = '0;
        made    = 1'b0;
        present = 1'b0;
        found   = 1'b0;
        hot     = i_st.fn && (i_code == CODE_Z || i_code == CODE_X || i_code == CODE_C);
        is_mod  = (i_code >= MOD_FIRST) && (i_code <= MOD_LAST);
        mod_bit = 8'd1 << i_code[2:0];
        if (i_code == CODE_NONE) begin
            made = 1'b0;
        end else if (i_code == CODE_FN) begin
            st.fn = i_press;
        end else if (hot) begin
            if (i_press) begin
                made     = 1'b1;
                res.kind = 1'b1;
                if (i_code == CODE_Z) begin
                    res.bright = BL_FULL;
                end else begin
                    if (i_code == CODE_X) begin
                        st.bright = i_st.bright + BL_STEP;
                    end else begin
                        st.bright = i_st.bright - BL_STEP;
                    end
                    res.bright = st.bright;
                end
            end
        end else if (i_press) begin
            if (is_mod) begin
                st.mods = i_st.mods | mod_bit;
            end
            for (int i = 0; i < NSLOTS; i++) begin
                if (i_st.slots[i] == i_code) begin
                    present = 1'b1;
                end
            end
            if (present) begin
                made = 1'b1;
            end else begin
                for (int i = 0; i < NSLOTS; i++) begin
                    if (!found && i_st.slots[i] == CODE_NONE) begin
                        st.slots[i] = i_code;
                        found       = 1'b1;
                    end
                end
                made = found;
            end
        end else begin
            if (is_mod) begin
                st.mods = i_st.mods & ~mod_bit;
            end
            for (int i = 0; i < NSLOTS; i++) begin
                if (i_st.slots[i] == i_code) begin
                    st.slots[i] = CODE_NONE;
                end
            end
            made = 1'b1;
        end
        if (made && !res.kind) begin
            res.mods  = st.mods;
            res.slots = st.slots;
        end
        o_evt.made = made;
        o_evt.st   = st;
        o_evt.res  = res;
    end
endmodule
